[rtl/core/fractal_perlin_noise_unit_defines.svh]
// Assertion macros for the fractal noise unit.
// Both take a label, a clock, an active-low reset and a property expression.
`ifndef FRACTAL_PERLIN_NOISE_UNIT_DEFINES_SVH
`define FRACTAL_PERLIN_NOISE_UNIT_DEFINES_SVH
`ifndef SYNTH
// property must hold at every edge outside reset
`define FPN_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("fractal noise unit assertion failed");
// expression must never be true outside reset
`define FPN_ASSERT_NEVER(lbl, clk_s, rstn_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
        else $error("fractal noise unit forbidden condition seen");
`else
`define FPN_ASSERT(lbl, clk_s, rstn_s, prop)
`define FPN_ASSERT_NEVER(lbl, clk_s, rstn_s, expr)
`endif
`endif

[rtl/core/fpn_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpn_pkg
// Types, constants and arithmetic helpers shared by the fractal noise unit.
// ---------------------------------------------------------------------------
package fpn_pkg;

    // opcodes
    localparam logic [1:0] OP_NOISE = 2'd0;
    localparam logic [1:0] OP_FBM   = 2'd1;
    localparam logic [1:0] OP_TURB  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_OCTAVE_COUNT = 2'd0;
    localparam logic [1:0] CFG_OMEGA_GAIN   = 2'd1;

    localparam logic [3:0]  OCTAVE_COUNT_RST = 4'd8;
    localparam logic [15:0] OMEGA_GAIN_RST   = 16'd32768;

    // 1.99 in Q1.16
    localparam logic [16:0] LACUNARITY_Q16 = 17'd130417;
    localparam logic [31:0] ONE_Q16        = 32'd65536;

    // pipeline length of one octave pass
    localparam int          PHASE_W    = 4;
    localparam logic [3:0]  PHASE_LAST = 4'd10;

    localparam int PERM_SIZE = 256;

    localparam logic [7:0] PERM [PERM_SIZE] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    // controller to datapath
    typedef struct packed {
        logic load;      // take the input transfer
        logic acc;       // end of octave: accumulate, step lambda and amplitude
        logic out_load;  // move the saturated sum to the output register
    } fpn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic zero_req;  // presented item needs no octave pass
        logic last_oct;  // current octave is the final one
    } fpn_status_t;

    // gradient dot product, twelve directions
    function automatic logic signed [18:0] grad(input logic [3:0] h,
                                                input logic signed [17:0] dx,
                                                input logic signed [17:0] dy,
                                                input logic signed [17:0] dz);
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = (h < 4'd8 || h == 4'd12 || h == 4'd13) ? 19'(dx) : 19'(dy);
        v = (h < 4'd4 || h == 4'd12 || h == 4'd13) ? 19'(dy) : 19'(dz);
        if (h[0])
            u = -u;
        if (h[1])
            v = -v;
        return u + v;
    endfunction

    // a + round(w * (b - a) / 2^16)
    function automatic logic signed [19:0] lerp_q16(input logic [16:0] w,
                                                    input logic signed [19:0] a,
                                                    input logic signed [19:0] b);
        logic signed [20:0] d;
        logic signed [38:0] pr;
        logic signed [38:0] rs;
        d  = 21'(b) - 21'(a);
        pr = $signed({1'b0, w}) * d;
        rs = (pr + 39'sd32768) >>> 16;
        return a + $signed(rs[19:0]);
    endfunction

endpackage

[rtl/core/fractal_perlin_noise_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fractal_perlin_noise_unit
// Improved 3D gradient noise with fBm and turbulence octave sums.
// ---------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | opcode, coord_x, coord_y, coord_z
// out     | output    | out_valid / out_stall | noise_value
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One item runs one pass of the octave pipeline per octave, after the input
// transfer and before the hand-over: one pass for single noise, up to
// MAX_OCTAVES for fBm and turbulence. Reset is asynchronous, active low,
// and restores octave_count 8 and omega_gain 0.5. A stalled output register
// holds its value; the next input is taken while it waits.
// ---------------------------------------------------------------------------
`include "fractal_perlin_noise_unit_defines.svh"

module fractal_perlin_noise_unit
    import fpn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] noise_value
);

    fpn_cmd_t    cmd;
    fpn_status_t status;

    fpn_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fpn_datapath #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .cmd         (cmd),
        .status      (status),
        .noise_value (noise_value)
    );

    // busy straight after taking an item
    `FPN_ASSERT(a_busy_after_take, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
    // a hand-over always raises the output valid
    `FPN_ASSERT(a_load_sets_valid, clk, rst_n, cmd.out_load |=> out_valid)
    // never accumulate while idle and taking a new item
    `FPN_ASSERT_NEVER(a_no_acc_on_take, clk, rst_n, cmd.acc && cmd.load)
    // never overwrite a waiting result
    `FPN_ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && out_valid && out_stall)

endmodule

[rtl/core/fpn_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpn_ctrl
// Sequencer: takes a transfer, runs octave passes, hands over the result.
// ---------------------------------------------------------------------------
module fpn_ctrl
    import fpn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  fpn_status_t status,
    output fpn_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               ovalid_reg, ovalid_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        ovalid_next  = ovalid_reg;
        cmd          = '0;
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = '0;
                    state_next = status.zero_req ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == PHASE_LAST)
                begin
                    cmd.acc    = 1'b1;
                    phase_next = '0;
                    if (status.last_oct)
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;

endmodule

[rtl/core/fpn_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpn_datapath
// Octave pipeline: coordinate scaling, hashing, fade, blending, accumulation.
// ---------------------------------------------------------------------------
module fpn_datapath
    import fpn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  fpn_cmd_t           cmd,
    output fpn_status_t        status,
    output logic signed [23:0] noise_value
);

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

    // configuration
    logic [3:0]  oct_cnt_reg;
    logic [15:0] omega_reg;

    // per-item state
    logic signed [31:0] p_reg [3];
    logic [1:0]         op_reg;
    logic [31:0]        lam_reg;
    logic [16:0]        amp_reg;
    logic [OCT_W-1:0]   n_reg;
    logic [OCT_W-1:0]   oct_reg;
    logic signed [27:0] sum_reg;
    logic signed [23:0] out_reg;

    // pipeline registers
    logic [39:0]        m1_reg   [3];
    logic [23:0]        m2_reg   [3];
    logic [7:0]         cell_reg [3];
    logic [15:0]        frac_reg [3];
    logic [31:0]        tt_reg   [3];
    logic signed [38:0] pq_reg   [3];
    logic [31:0]        t3_reg   [3];
    logic [19:0]        q_reg    [3];
    logic [16:0]        w_reg    [3];
    logic [7:0]         ha_reg   [2];
    logic [7:0]         hb_reg   [4];
    logic [3:0]         hc_reg   [8];
    logic signed [18:0] g_reg    [8];
    logic signed [19:0] x_reg    [4];
    logic signed [19:0] y_reg    [2];
    logic signed [19:0] nz_reg;
    logic signed [21:0] term_reg;

    // combinational helpers
    logic signed [48:0] m1_full  [3];
    logic [39:0]        m2_full  [3];
    logic [39:0]        sv       [3];
    logic signed [21:0] f6       [3];
    logic signed [38:0] pq_full  [3];
    logic [47:0]        t3_full  [3];
    logic signed [38:0] q_full   [3];
    logic [52:0]        w_full   [3];
    logic signed [17:0] dd       [3][2];
    logic signed [19:0] nabs;
    logic signed [37:0] term_full;
    logic [48:0]        lam_full;
    logic [32:0]        amp_full;
    logic [OCT_W-1:0]   n_req;
    logic               clamp;

    // octave count for the presented item
    assign clamp = ({28'd0, oct_cnt_reg} > MAX_OCTAVES);
    always_comb
    begin
        case (opcode)
            OP_NOISE: n_req = OCT_W'(1);
            OP_NONE:  n_req = '0;
            default:  n_req = clamp ? OCT_W'(MAX_OCTAVES) : OCT_W'(oct_cnt_reg);
        endcase
    end

    assign status.zero_req = (n_req == '0);
    assign status.last_oct = (oct_reg == n_reg - 1'b1);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_cnt_reg <= OCTAVE_COUNT_RST;
            omega_reg   <= OMEGA_GAIN_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_OCTAVE_COUNT)
                oct_cnt_reg <= cfg_data[3:0];
            else if (cfg_index == CFG_OMEGA_GAIN)
                omega_reg <= cfg_data;
        end
    end

    // per-axis arithmetic
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m1_full[i] = p_reg[i] * $signed({1'b0, lam_reg[15:0]});
            m2_full[i] = 40'(p_reg[i][23:0] * lam_reg[31:16]);
            sv[i]      = m1_reg[i] + {m2_reg[i], 16'd0} + 40'd32768;
            f6[i]      = $signed({6'd0, frac_reg[i]}) * 22'sd6 - 22'sd983040;
            pq_full[i] = f6[i] * $signed({1'b0, frac_reg[i]});
            t3_full[i] = 48'(tt_reg[i]) * 48'(frac_reg[i]);
            q_full[i]  = pq_reg[i] + 39'sd42949672960 + 39'sd32768;
            w_full[i]  = 53'(t3_reg[i]) * 53'(q_reg[i]) + 53'd2147483648;
            dd[i][0]   = $signed({2'b00, frac_reg[i]});
            dd[i][1]   = $signed({2'b00, frac_reg[i]}) - 18'sd65536;
        end
    end

    // octave term, and lambda and amplitude steps rounded to nearest
    assign nabs      = (op_reg == OP_TURB && nz_reg < 0) ? -nz_reg : nz_reg;
    assign term_full = $signed({1'b0, amp_reg}) * nabs;
    assign lam_full  = 49'(lam_reg) * 49'(LACUNARITY_Q16) + 49'd32768;
    assign amp_full  = 33'(amp_reg) * 33'(omega_reg) + 33'd32768;

    // octave pipeline, free running on stable per-item state
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            m1_reg[i]   <= m1_full[i][39:0];
            m2_reg[i]   <= m2_full[i][23:0];
            cell_reg[i] <= sv[i][39:32];
            frac_reg[i] <= sv[i][31:16];
            tt_reg[i]   <= 32'(frac_reg[i]) * 32'(frac_reg[i]);
            pq_reg[i]   <= pq_full[i];
            t3_reg[i]   <= t3_full[i][47:16];
            q_reg[i]    <= q_full[i][35:16];
            w_reg[i]    <= w_full[i][48:32];
        end
        // hash, one permutation level a cycle
        for (int a = 0; a < 2; a++)
            ha_reg[a] <= PERM[cell_reg[0] + 8'(a)];
        for (int b = 0; b < 4; b++)
            hb_reg[b] <= PERM[ha_reg[b & 1] + cell_reg[1] + 8'(b >> 1)];
        for (int c = 0; c < 8; c++)
            hc_reg[c] <= PERM[hb_reg[c & 3] + cell_reg[2] + 8'(c >> 2)][3:0];
        for (int c = 0; c < 8; c++)
            g_reg[c] <= grad(hc_reg[c], dd[0][c & 1], dd[1][(c >> 1) & 1],
                             dd[2][(c >> 2) & 1]);
        // trilinear blend
        for (int j = 0; j < 4; j++)
            x_reg[j] <= lerp_q16(w_reg[0], 20'(g_reg[2*j]), 20'(g_reg[2*j+1]));
        y_reg[0] <= lerp_q16(w_reg[1], x_reg[0], x_reg[1]);
        y_reg[1] <= lerp_q16(w_reg[1], x_reg[2], x_reg[3]);
        nz_reg   <= lerp_q16(w_reg[2], y_reg[0], y_reg[1]);
        term_reg <= 22'((term_full + 38'sd32768) >>> 16);
    end

    // per-item state and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= OP_NOISE;
            n_reg   <= '0;
            oct_reg <= '0;
        end
        else if (cmd.load)
        begin
            op_reg  <= opcode;
            n_reg   <= n_req;
            oct_reg <= '0;
        end
        else if (cmd.acc)
        begin
            oct_reg <= oct_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg[0] <= coord_x;
            p_reg[1] <= coord_y;
            p_reg[2] <= coord_z;
            lam_reg  <= ONE_Q16;
            amp_reg  <= 17'(ONE_Q16);
            sum_reg  <= '0;
        end
        else if (cmd.acc)
        begin
            sum_reg <= sum_reg + 28'(term_reg);
            lam_reg <= lam_full[47:16];
            amp_reg <= amp_full[32:16];
        end
        // saturate to Q8.16
        if (cmd.out_load)
        begin
            if (sum_reg > 28'sd8388607)
                out_reg <= 24'sh7FFFFF;
            else if (sum_reg < -28'sd8388608)
                out_reg <= 24'sh800000;
            else
                out_reg <= sum_reg[23:0];
        end
    end

    assign noise_value = out_reg;

endmodule
